FILE: hdl/fsc_pkg.sv
package fsc_pkg;

	localparam int WORD_BITS_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [1:0] MODE_LOAD_PROJ = 2'd0;
	localparam logic [1:0] MODE_LOAD_VIEW = 2'd1;
	localparam logic [1:0] MODE_REBUILD   = 2'd2;
	localparam logic [1:0] MODE_SPHERE    = 2'd3;

	localparam logic KIND_REBUILD = 1'b0;
	localparam logic KIND_SPHERE  = 1'b1;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
		logic signed [31:0] sphere_x;
		logic signed [31:0] sphere_y;
		logic signed [31:0] sphere_z;
		logic [30:0]        sphere_radius;
	} cmd_t;

	typedef struct packed {
		logic result_kind;
		logic visible;
	} result_t;

endpackage

FILE: hdl/frustum_sphere_culler.sv
// Frustum sphere culler.
//
// Command channel: an item on cmd is taken at a rising edge with start high
// and busy low. Mode 0/1 writes one projection/view element (row*4+col);
// these finish in the accept cycle, give no result and leave busy low.
// Mode 2 forms M = P*V, extracts the six clip planes (row3 -/+ row0, row2,
// row1) and normalizes each by the length of its normal. Mode 3 tests a
// sphere against the stored planes.
// Result channel: result_valid pulses for one cycle with result; the
// receiver cannot stall, so every result is a transaction in that cycle.
// busy falls in the same cycle as the strobe.
// All work uses one shared W x max(W,32) multiplier, a one-bit-per-
// cycle square root and a one-bit-per-cycle restoring divider:
//   sphere test: per plane 3 products, each a multiply then an
//     accumulate, then the offset and compare, for up to 6 planes;
//     with culling off the result comes back with busy left low.
//   rebuild: the matrix product, then per plane the coefficient sums,
//     the squares, the root and the divides (none for a zero normal).
// Reset clears both matrices and the planes to zero and sets cull_enable.
// cfg_we/cfg_wdata write cull_enable; write it only while idle.
module frustum_sphere_culler #(
	parameter int WORD_BITS     = fsc_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = fsc_pkg::FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fsc_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             result_valid,
	output fsc_pkg::result_t result,
	input  logic             cfg_we,
	input  logic             cfg_wdata
);
	import fsc_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int MB  = (W > 32) ? W : 32;   // multiplier B operand width
	localparam int PW  = W + MB;              // product width
	localparam int AW  = PW + 3;              // accumulator width
	localparam int DW  = MB + 1;              // plane offset plus radius
	localparam int W1  = W + 1;
	localparam int NW  = 2 * W;               // square root input width
	localparam int DV  = W + F;               // divider dividend width
	localparam int CW  = $clog2(DV + 1);

	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [DV-1:0] QLIM = DV'(1) << (W - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MMUL = 3'd1;
	localparam logic [2:0] ST_PSUM = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_SPH  = 3'd6;

	// matrices and planes
	logic signed [W-1:0] proj_q  [16];
	logic signed [W-1:0] view_q  [16];
	logic signed [W-1:0] m3_q    [4];    // row 3 of P*V
	logic signed [W-1:0] mo_q    [12];   // rows 0..2 of P*V
	logic signed [W-1:0] plane_q [24];
	logic signed [W-1:0] coef_q  [4];    // plane under construction

	logic [2:0]  state_q;
	logic [2:0]  idx_q;      // matrix row or plane number
	logic [1:0]  col_q;      // column or coefficient
	logic [1:0]  k_q;        // inner product term
	logic        ph_q;       // 0: multiply, 1: accumulate
	logic [CW-1:0] cnt_q;
	logic        div_run_q;
	logic        cull_en_q;

	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;

	logic [NW-1:0] sq_n_q;
	logic [W-1:0]  sq_rem_q;
	logic [W-1:0]  root_q;

	logic [DV-1:0] dvd_q;
	logic [DV-1:0] quo_q;
	logic [W-1:0]  drem_q;

	logic signed [31:0] sx_q, sy_q, sz_q;
	logic [30:0]        rad_q;

	logic    result_valid_q;
	result_t result_q;

	// shared multiplier operands
	logic signed [W-1:0]  mul_a;
	logic signed [MB-1:0] mul_b;

	always_comb begin
		mul_a = proj_q[{idx_q[1:0], k_q}];
		mul_b = MB'(view_q[{k_q, col_q}]);
		case (state_q)
			ST_SQ: begin
				mul_a = coef_q[col_q];
				mul_b = MB'(coef_q[col_q]);
			end
			ST_SPH: begin
				mul_a = plane_q[{idx_q, col_q}];
				case (col_q)
					2'd0:    mul_b = MB'(sx_q);
					2'd1:    mul_b = MB'(sy_q);
					default: mul_b = MB'(sz_q);
				endcase
			end
			default: ;
		endcase
	end

	// running sum and its truncated, saturated word
	logic signed [AW-1:0] acc_sum;
	logic signed [AW-1:0] acc_shr;
	logic                 acc_fits;
	logic signed [W-1:0]  acc_word;

	assign acc_sum  = acc_q + AW'(prod_q);
	assign acc_shr  = acc_sum >>> F;
	assign acc_fits = (&acc_shr[AW-1:W-1]) | ~(|acc_shr[AW-1:W-1]);
	assign acc_word = acc_fits ? acc_shr[W-1:0] : (acc_shr[AW-1] ? WMIN : WMAX);

	// incoming element, saturated to the word
	logic signed [MB-1:0] elem_ext;
	logic                 elem_fits;
	logic signed [W-1:0]  elem_word;

	assign elem_ext  = MB'(cmd.element_value);
	assign elem_fits = (&elem_ext[MB-1:W-1]) | ~(|elem_ext[MB-1:W-1]);
	assign elem_word = elem_fits ? elem_ext[W-1:0] : (elem_ext[MB-1] ? WMIN : WMAX);

	// plane coefficient: row 3 plus or minus the paired row
	logic [1:0]          pair_row;
	logic signed [W1-1:0] psum;
	logic signed [W-1:0]  psum_word;

	always_comb begin
		case (idx_q) inside
			3'd0, 3'd1: pair_row = 2'd0;
			3'd2, 3'd3: pair_row = 2'd2;
			default:    pair_row = 2'd1;
		endcase
	end

	assign psum = idx_q[0] ? (W1'(m3_q[col_q]) + W1'(mo_q[{pair_row, col_q}]))
	                       : (W1'(m3_q[col_q]) - W1'(mo_q[{pair_row, col_q}]));
	assign psum_word = (psum[W] == psum[W-1]) ? psum[W-1:0] : (psum[W] ? WMIN : WMAX);

	// square root step, two radicand bits per cycle
	logic [W+1:0] sq_rn;
	logic [W+1:0] sq_trial;
	logic         sq_ge;

	assign sq_rn    = {sq_rem_q, sq_n_q[NW-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = sq_rn >= sq_trial;

	// restoring divide step
	logic [W:0]          dv_sh;
	logic                dv_ge;
	logic [W-1:0]        coef_mag;
	logic signed [W-1:0] div_word;

	assign dv_sh    = {drem_q, dvd_q[DV-1]};
	assign dv_ge    = dv_sh >= {1'b0, root_q};
	assign coef_mag = coef_q[col_q][W-1] ? W'(-coef_q[col_q]) : W'(coef_q[col_q]);

	always_comb begin
		if (coef_q[col_q][W-1]) begin
			div_word = (quo_q > QLIM) ? WMIN : -$signed(quo_q[W-1:0]);
		end else begin
			div_word = (quo_q >= QLIM) ? WMAX : $signed(quo_q[W-1:0]);
		end
	end

	// sphere distance: products plus (d + r) << F
	logic signed [DW-1:0] dr;
	logic signed [AW-1:0] sdist;
	logic                 culled;

	assign dr     = DW'(plane_q[{idx_q, 2'd3}]) + DW'($signed({1'b0, rad_q}));
	assign sdist  = acc_q + (AW'(dr) <<< F);
	assign culled = sdist[AW-1] | (sdist == '0);

	assign busy         = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			col_q          <= '0;
			k_q            <= '0;
			ph_q           <= 1'b0;
			cnt_q          <= '0;
			div_run_q      <= 1'b0;
			cull_en_q      <= 1'b1;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				proj_q[i] <= '0;
				view_q[i] <= '0;
			end
			for (int i = 0; i < 24; i++) begin
				plane_q[i] <= '0;
			end
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				cull_en_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						sx_q  <= cmd.sphere_x;
						sy_q  <= cmd.sphere_y;
						sz_q  <= cmd.sphere_z;
						rad_q <= cmd.sphere_radius;
						idx_q <= '0;
						col_q <= '0;
						k_q   <= '0;
						ph_q  <= 1'b0;
						acc_q <= '0;
						unique case (cmd.mode)
							MODE_LOAD_PROJ: proj_q[cmd.element_index] <= elem_word;
							MODE_LOAD_VIEW: view_q[cmd.element_index] <= elem_word;
							MODE_REBUILD:   state_q <= ST_MMUL;
							MODE_SPHERE: begin
								if (cull_en_q) begin
									state_q <= ST_SPH;
								end else begin
									result_valid_q       <= 1'b1;
									result_q.result_kind <= KIND_SPHERE;
									result_q.visible     <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end

				ST_MMUL: begin
					if (!ph_q) begin
						prod_q <= mul_a * mul_b;
						ph_q   <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (k_q != 2'd3) begin
							acc_q <= acc_sum;
							k_q   <= k_q + 2'd1;
						end else begin
							acc_q <= '0;
							k_q   <= '0;
							if (idx_q[1:0] == 2'd3) begin
								m3_q[col_q] <= acc_word;
							end else begin
								mo_q[{idx_q[1:0], col_q}] <= acc_word;
							end
							col_q <= col_q + 2'd1;
							if (col_q == 2'd3) begin
								if (idx_q[1:0] == 2'd3) begin
									idx_q   <= '0;
									state_q <= ST_PSUM;
								end else begin
									idx_q <= idx_q + 3'd1;
								end
							end
						end
					end
				end

				ST_PSUM: begin
					coef_q[col_q] <= psum_word;
					col_q         <= col_q + 2'd1;
					if (col_q == 2'd3) begin
						ph_q    <= 1'b0;
						acc_q   <= '0;
						state_q <= ST_SQ;
					end
				end

				ST_SQ: begin
					if (!ph_q) begin
						prod_q <= mul_a * mul_b;
						ph_q   <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						acc_q <= acc_sum;
						if (col_q == 2'd2) begin
							col_q    <= '0;
							sq_n_q   <= acc_sum[NW-1:0];
							sq_rem_q <= '0;
							root_q   <= '0;
							cnt_q    <= '0;
							state_q  <= ST_SQRT;
						end else begin
							col_q <= col_q + 2'd1;
						end
					end
				end

				ST_SQRT: begin
					sq_rem_q <= sq_ge ? W'(sq_rn - sq_trial) : sq_rn[W-1:0];
					root_q   <= {root_q[W-2:0], sq_ge};
					sq_n_q   <= sq_n_q << 2;
					cnt_q    <= cnt_q + CW'(1);
					if (cnt_q == CW'(W - 1)) begin
						div_run_q <= 1'b0;
						state_q   <= ST_DIV;
					end
				end

				ST_DIV: begin
					if (!div_run_q) begin
						if (root_q == '0) begin
							// zero normal: plane stays unnormalized
							plane_q[{idx_q, col_q}] <= coef_q[col_q];
						end else begin
							dvd_q     <= {coef_mag, {F{1'b0}}};
							drem_q    <= '0;
							quo_q     <= '0;
							cnt_q     <= '0;
							div_run_q <= 1'b1;
						end
					end else if (cnt_q != CW'(DV)) begin
						drem_q <= dv_ge ? W'(dv_sh - {1'b0, root_q}) : dv_sh[W-1:0];
						quo_q  <= {quo_q[DV-2:0], dv_ge};
						dvd_q  <= dvd_q << 1;
						cnt_q  <= cnt_q + CW'(1);
					end else begin
						plane_q[{idx_q, col_q}] <= div_word;
						div_run_q               <= 1'b0;
					end

					if ((!div_run_q && root_q == '0) || (div_run_q && cnt_q == CW'(DV))) begin
						col_q <= col_q + 2'd1;
						if (col_q == 2'd3) begin
							if (idx_q == 3'd5) begin
								state_q              <= ST_IDLE;
								result_valid_q       <= 1'b1;
								result_q.result_kind <= KIND_REBUILD;
								result_q.visible     <= 1'b0;
							end else begin
								idx_q   <= idx_q + 3'd1;
								state_q <= ST_PSUM;
							end
						end
					end
				end

				ST_SPH: begin
					if (col_q != 2'd3) begin
						if (!ph_q) begin
							prod_q <= mul_a * mul_b;
							ph_q   <= 1'b1;
						end else begin
							ph_q  <= 1'b0;
							acc_q <= acc_sum;
							col_q <= col_q + 2'd1;
						end
					end else begin
						col_q <= '0;
						acc_q <= '0;
						if (culled || idx_q == 3'd5) begin
							state_q              <= ST_IDLE;
							result_valid_q       <= 1'b1;
							result_q.result_kind <= KIND_SPHERE;
							result_q.visible     <= ~culled;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/fsc_checker.sv
module fsc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input fsc_pkg::cmd_t    cmd,
	input logic             busy,
	input logic             result_valid,
	input fsc_pkg::result_t result
);
	import fsc_pkg::*;

	// a load transaction never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.mode == MODE_LOAD_PROJ || cmd.mode == MODE_LOAD_VIEW)
		|=> !result_valid)
		else $error("result after a matrix load");

	// a rebuild keeps the block busy, without a result, after it is accepted
	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.mode == MODE_REBUILD |=> busy && !result_valid)
		else $error("rebuild did not hold busy");

	// busy only drops together with a result strobe
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy fell without a result");

	// rebuild completion reports visible low
	a_rebuild_vis: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_REBUILD |-> !result.visible)
		else $error("rebuild result with visible set");

endmodule

bind frustum_sphere_culler fsc_checker u_fsc_checker (.*);

FILE: dv/frustum_sphere_culler_tb.sv
module frustum_sphere_culler_tb;
	import fsc_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	// A pending transaction for the driver. A hold entry pauses the driver
	// until nothing is outstanding; a hold with a config write changes
	// cull_enable while the block is idle.
	typedef struct {
		bit    hold;
		bit    cfg_write;
		bit    cfg_value;
		cmd_t  c;
	} pend_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    cfg_we = 1'b0;
	logic    cfg_wdata = 1'b0;
	logic    busy;
	logic    result_valid;
	result_t result;

	frustum_sphere_culler uut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: its own copy of the matrices, planes and register.
	longint  proj_m[16];
	longint  view_m[16];
	longint  planes[24];
	bit      cull_on;

	pend_t   pending_q[$];
	result_t expected_q[$];
	int      fail_count = 0;
	int      rebuilds_seen = 0, spheres_seen = 0, culled_seen = 0;
	bit      stim_done = 1'b0;
	bit      quiet = 1'b0;   // no-idle stretch for the driver

	bit      taken_last = 1'b1;
	int      hold_wait = 0;
	int      idle_cycles = 0;
	pend_t   next_e;
	logic    we_next;
	result_t exp_r;

	function automatic longint clamp_word(input logic signed [127:0] v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return longint'(v);
	endfunction

	function automatic logic signed [127:0] floor_sqrt(input logic signed [127:0] n);
		logic signed [127:0] r, c;
		r = 0;
		for (int b = 50; b >= 0; b--) begin
			c = r | (128'sd1 <<< b);
			if (c * c <= n) r = c;
		end
		return r;
	endfunction

	// M = P*V, six planes from row 3 -/+ rows 0, 2, 1, each normalized
	// by its normal length unless that length is zero.
	function automatic void rebuild_frustum();
		longint m[16];
		int pair[6] = '{0, 0, 2, 2, 1, 1};
		logic signed [127:0] acc, ss, len, q;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += 128'(proj_m[r*4+k]) * 128'(view_m[k*4+c]);
				m[r*4+c] = clamp_word(acc >>> FB);
			end
		for (int p = 0; p < 6; p++) begin
			for (int k = 0; k < 4; k++)
				planes[p*4+k] = clamp_word((p & 1) ?
					128'(m[12+k]) + 128'(m[pair[p]*4+k]) :
					128'(m[12+k]) - 128'(m[pair[p]*4+k]));
			ss = 0;
			for (int k = 0; k < 3; k++)
				ss += 128'(planes[p*4+k]) * 128'(planes[p*4+k]);
			len = floor_sqrt(ss);
			if (len == 0) continue;
			for (int k = 0; k < 4; k++) begin
				q = (128'(planes[p*4+k]) <<< FB) / len;  // truncates toward zero
				planes[p*4+k] = clamp_word(q);
			end
		end
	endfunction

	function automatic bit sphere_in_frustum(input cmd_t c);
		logic signed [127:0] s;
		if (!cull_on) return 1'b1;
		for (int p = 0; p < 6; p++) begin
			s = 128'(planes[p*4]) * 128'(c.sphere_x)
			  + 128'(planes[p*4+1]) * 128'(c.sphere_y)
			  + 128'(planes[p*4+2]) * 128'(c.sphere_z)
			  + ((128'(planes[p*4+3]) + 128'({1'b0, c.sphere_radius})) <<< FB);
			if (s <= 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void predict_transaction(input cmd_t c);
		result_t r;
		case (c.mode)
			MODE_LOAD_PROJ: proj_m[c.element_index] = longint'(c.element_value);
			MODE_LOAD_VIEW: view_m[c.element_index] = longint'(c.element_value);
			MODE_REBUILD: begin
				rebuild_frustum();
				r.result_kind = KIND_REBUILD;
				r.visible = 1'b0;
				expected_q.push_back(r);
			end
			default: begin
				r.result_kind = KIND_SPHERE;
				r.visible = sphere_in_frustum(c);
				expected_q.push_back(r);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Driver: idle at random about 27% of the time outside the quiet stretch.
	// A held entry (pause or config write) waits until nothing is expected,
	// then a few extra cycles before moving on.
	always @(negedge clk) begin
		if (arst_n) begin
			we_next = 1'b0;
			// an offer that was not taken stays on the bus unchanged
			if (!start || taken_last) begin
				if (pending_q.size() == 0) begin
					start <= 1'b0;
					if (!start) stim_done <= 1'b1;
				end else if (pending_q[0].hold) begin
					start <= 1'b0;
					if (expected_q.size() == 0) begin
						if (hold_wait >= 4) begin
							if (pending_q[0].cfg_write) begin
								we_next = 1'b1;
								cfg_wdata <= pending_q[0].cfg_value;
							end
							void'(pending_q.pop_front());
							hold_wait = 0;
						end else hold_wait++;
					end
				end else if (!quiet && $urandom_range(99) < 27) begin
					start <= 1'b0;
				end else begin
					next_e = pending_q.pop_front();
					start <= 1'b1;
					cmd   <= next_e.c;
				end
			end
			cfg_we <= we_next;
		end
	end

	// Acceptance sampled at the rising edge; prediction and the watchdog
	// on cycles with nothing accepted live here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_transaction(cmd);
			end else if (cfg_we) begin
				cull_on = cfg_wdata;
			end
			taken_last = !start || !busy;
			if ((start && !busy) || cfg_we || result_valid) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("watchdog expired, %0d results outstanding", expected_q.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Monitor: every strobe is a result transaction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				exp_r = expected_q.pop_front();
				if (result.result_kind !== exp_r.result_kind)
					report_mismatch($sformatf("result_kind got %b want %b",
						result.result_kind, exp_r.result_kind));
				if (result.visible !== exp_r.visible)
					report_mismatch($sformatf("visible got %b want %b (kind %b)",
						result.visible, exp_r.visible, exp_r.result_kind));
				if (exp_r.result_kind == KIND_SPHERE) begin
					spheres_seen++;
					if (!exp_r.visible) culled_seen++;
				end else rebuilds_seen++;
			end
		end
	end

	// ---- stimulus helpers ----
	function automatic cmd_t rand_cmd(input logic [1:0] mode);
		cmd_t c;
		c.mode = mode;
		c.element_index = 4'($urandom);
		c.element_value = 32'($urandom);
		c.sphere_x = 32'($urandom);
		c.sphere_y = 32'($urandom);
		c.sphere_z = 32'($urandom);
		c.sphere_radius = 31'($urandom);
		return c;
	endfunction

	// Small Q16.16 value, in [-range, range] units with random fraction.
	function automatic logic signed [31:0] modest(input int range);
		return 32'(($urandom_range(2 * range) - range) <<< FB) + 32'($urandom_range(65535));
	endfunction

	function automatic void push_item(input cmd_t c);
		pend_t e;
		e.hold = 0; e.cfg_write = 0; e.cfg_value = 0; e.c = c;
		pending_q.push_back(e);
	endfunction

	function automatic void push_hold(input bit wr, input bit v);
		pend_t e;
		e.hold = 1; e.cfg_write = wr; e.cfg_value = v; e.c = '0;
		pending_q.push_back(e);
	endfunction

	function automatic void push_load(input logic [1:0] mode, input int idx,
			input logic signed [31:0] v);
		cmd_t c;
		c = rand_cmd(mode);
		c.element_index = 4'(idx);
		c.element_value = v;
		push_item(c);
	endfunction

	// A plausible frame: projection/view with modest entries, a rebuild,
	// then a batch of spheres near the origin.
	function automatic void push_frame(input int spheres);
		cmd_t c;
		for (int i = 0; i < 16; i++)
			if ($urandom_range(3) != 0)
				push_load(MODE_LOAD_PROJ, i, (i % 5 == 0) ? 32'sh10000 + modest(1) : modest(2));
		for (int i = 0; i < 16; i++)
			if ($urandom_range(3) != 0)
				push_load(MODE_LOAD_VIEW, i, (i % 5 == 0) ? 32'sh10000 : modest(4));
		push_item(rand_cmd(MODE_REBUILD));
		for (int s = 0; s < spheres; s++) begin
			c = rand_cmd(MODE_SPHERE);
			if ($urandom_range(9) != 0) begin
				c.sphere_x = modest(3);
				c.sphere_y = modest(3);
				c.sphere_z = modest(3);
				c.sphere_radius = 31'($urandom_range(3 << FB));
			end
			push_item(c);
		end
	endfunction

	initial begin
		cmd_t c;
		int total;
		foreach (proj_m[i]) begin proj_m[i] = 0; view_m[i] = 0; end
		foreach (planes[i]) planes[i] = 0;
		cull_on = 1'b1;

		// Directed: zero planes (zero normal), extremes, culling on and off.
		c = rand_cmd(MODE_SPHERE);
		c.sphere_radius = '0;
		push_item(c);                                  // distance exactly zero: culled
		c.sphere_radius = 31'h7FFFFFFF;
		push_item(c);
		push_item(rand_cmd(MODE_REBUILD));             // all-zero matrices
		push_load(MODE_LOAD_PROJ, 0, 32'sh7FFFFFFF);
		push_load(MODE_LOAD_PROJ, 15, 32'sh80000000);
		push_load(MODE_LOAD_VIEW, 0, 32'sh7FFFFFFF);
		push_load(MODE_LOAD_VIEW, 15, 32'sh7FFFFFFF);
		push_load(MODE_LOAD_VIEW, 3, 32'sh80000000);
		push_item(rand_cmd(MODE_REBUILD));             // saturating product and sums
		c.mode = MODE_SPHERE;
		c.sphere_x = 32'sh7FFFFFFF; c.sphere_y = 32'sh80000000; c.sphere_z = 32'sh0;
		c.sphere_radius = 31'h7FFFFFFF;
		push_item(c);
		c.sphere_x = 32'sh80000000; c.sphere_radius = '0;
		push_item(c);
		push_hold(1'b1, 1'b0);                         // culling off
		push_item(c);
		push_item(rand_cmd(MODE_SPHERE));
		push_hold(1'b1, 1'b1);                         // back on
		push_frame(4);

		// Random: mostly well-formed frames, some noise, cull setting toggled.
		total = 0;
		while (total < 2000) begin
			if ($urandom_range(9) == 0) begin
				push_hold(1'b1, $urandom_range(3) != 0);
			end else if ($urandom_range(4) == 0) begin
				for (int i = 0; i < 8; i++) push_item(rand_cmd(2'($urandom_range(3))));
				total += 8;
			end else begin
				push_frame(8 + $urandom_range(16));
				total += 40;
			end
			if ($urandom_range(15) == 0) push_hold(1'b0, 1'b0);
		end
		push_hold(1'b1, 1'b1);

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// quiet stretch early in the run
		repeat (300) @(posedge clk);
		quiet = 1'b1;
		repeat (1500) @(posedge clk);
		quiet = 1'b0;

		wait (stim_done);
		wait (expected_q.size() == 0);
		repeat (60) @(posedge clk);
		$display("covered %0d plane rebuilds and %0d sphere tests (%0d culled)",
			rebuilds_seen, spheres_seen, culled_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
